// ===== src/drs_pkg.sv =====
// Shared constants and types of the disk request scheduler.
`timescale 1ns / 1ps

package drs_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] POL_FIFO  = 3'd0;
	localparam logic [2:0] POL_SSTF  = 3'd1;
	localparam logic [2:0] POL_LOOK  = 3'd2;
	localparam logic [2:0] POL_CLOOK = 3'd3;
	localparam logic [2:0] POL_FLOOK = 3'd4;

	localparam logic [1:0] ST_ADDED   = 2'd0;
	localparam logic [1:0] ST_GRANTED = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_PICK = 1'b1;

	typedef struct packed {
		logic        batch;
		logic [15:0] ident;
		logic [15:0] track;
	} entry_t;

endpackage

// ===== src/disk_request_scheduler.sv =====
// Top level of the disk request scheduler: request store, scan sequencer and result register.
`timescale 1ns / 1ps

// Usage: items arrive on the s_ stream. s_tuser is the operation (add or pick);
// s_tdata carries the request id, the request track and the head track.
// Each item yields one result on the m_ stream: m_tuser is the status,
// m_tdata the granted id, the granted track and the sweep direction.
// The user writes the policy register through cfg_we / cfg_wdata only while idle;
// the block itself does not enforce this. An add or a refused/empty item goes
// straight to its result. A FIFO pick fetches and grants the entry at its position,
// then shifts the later entries of the store down; SSTF, LOOK and C-LOOK add a scan
// and a decision before that, and FLOOK one more batch check. Pick time is set by the
// single read port of the request memory: the scan and the gap-closing
// shift each visit one entry per cycle, the scan through one shared subtract/compare.
// One item is in work at a time; s_tready is high only while idle, and an
// item may be taken while the previous result still waits on m_.
// Reset clears the fill count, direction, active batch, policy and m_tvalid;
// the memory contents need no clearing. If m_tready is low, the finished
// result holds in the output register and the next result waits.
module disk_request_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // request_id, request_track, head_track
	input  logic [0:0]  s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // grant_id, grant_track, heading_up_out, zero pad
	output logic [1:0]  m_tuser   // status
);

	localparam int IW = drs_pkg::IDX_W;
	localparam int CW = drs_pkg::CNT_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_FETCH  = 3'd4;
	localparam logic [2:0] S_GRANT  = 3'd5;
	localparam logic [2:0] S_SHIFT  = 3'd6;
	localparam logic [2:0] S_FINISH = 3'd7;

	drs_pkg::entry_t mem [drs_pkg::QUEUE_DEPTH];
	drs_pkg::entry_t rdata_q;
	drs_pkg::entry_t mem_wd;
	logic            mem_we;
	logic [IW-1:0]   mem_wa;
	logic [IW-1:0]   mem_ra;

	logic [2:0]  state_q;
	logic [2:0]  policy_q;
	logic [CW-1:0] count_q;
	logic        heading_q;
	logic        active_q;
	logic [15:0] head_q;

	logic [CW-1:0] ptr_q;
	logic          pend_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] wa_q;
	logic [IW-1:0] k_q;

	logic          hit_q;
	logic [IW-1:0] hit_i_q;
	logic          up_ok_q;
	logic [15:0]   up_d_q;
	logic [IW-1:0] up_i_q;
	logic          dn_ok_q;
	logic [15:0]   dn_d_q;
	logic [IW-1:0] dn_i_q;
	logic          any_q;

	logic [1:0]  res_status_q;
	logic [15:0] res_id_q;
	logic [15:0] res_track_q;

	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [15:0] out_id_q;
	logic [15:0] out_track_q;
	logic        out_heading_q;

	logic        in_fire;
	logic        ptr_more;
	logic        is_clook;
	logic        is_look;
	logic        is_sstf;
	logic        elig;
	logic [16:0] diff;
	logic        t_eq;
	logic        t_gt;
	logic [15:0] gap;
	logic [15:0] cmp_ref;
	logic        d_less;
	logic        d_greater;
	logic [IW-1:0] dec_k;
	logic          dec_heading;

	assign s_tready = (state_q == S_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign ptr_more = (ptr_q < count_q);
	assign is_sstf  = (policy_q == drs_pkg::POL_SSTF);
	assign is_clook = (policy_q == drs_pkg::POL_CLOOK);
	assign is_look  = (policy_q == drs_pkg::POL_LOOK) || (policy_q == drs_pkg::POL_FLOOK);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {7'd0, out_heading_q, out_track_q, out_id_q};

	// shared distance and compare unit
	always_comb begin
		diff      = {1'b0, rdata_q.track} - {1'b0, head_q};
		t_eq      = (diff == 17'd0);
		t_gt      = !diff[16] && !t_eq;
		gap       = diff[16] ? (16'd0 - diff[15:0]) : diff[15:0];
		cmp_ref   = t_gt ? up_d_q : dn_d_q;
		d_less    = (gap < cmp_ref);
		d_greater = (gap > cmp_ref);
		elig      = (policy_q != drs_pkg::POL_FLOOK) || (rdata_q.batch == active_q);
	end

	always_comb begin
		dec_k       = dn_i_q;
		dec_heading = heading_q;
		if (hit_q) begin
			dec_k = hit_i_q;
			if (is_clook) begin
				dec_heading = 1'b1;
			end
		end else if (is_sstf) begin
			if (up_ok_q && dn_ok_q) begin
				if ((up_d_q < dn_d_q) || ((up_d_q == dn_d_q) && (up_i_q < dn_i_q))) begin
					dec_k = up_i_q;
				end else begin
					dec_k = dn_i_q;
				end
			end else if (up_ok_q) begin
				dec_k = up_i_q;
			end
		end else if (is_clook) begin
			if (up_ok_q) begin
				dec_k       = up_i_q;
				dec_heading = 1'b1;
			end else begin
				dec_heading = 1'b0;
			end
		end else if (is_look) begin
			if (heading_q) begin
				if (up_ok_q) begin
					dec_k = up_i_q;
				end else begin
					dec_heading = 1'b0;
				end
			end else if (!dn_ok_q) begin
				dec_k       = up_i_q;
				dec_heading = 1'b1;
			end
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = wa_q;
		mem_wd = rdata_q;
		mem_ra = ptr_q[IW-1:0];
		case (state_q)
			S_IDLE: begin
				mem_wa       = count_q[IW-1:0];
				mem_wd.batch = ~active_q;
				mem_wd.ident = s_tdata[15:0];
				mem_wd.track = s_tdata[31:16];
				mem_we       = in_fire && (s_tuser[0] == drs_pkg::OP_ADD) &&
				               (count_q < CW'(drs_pkg::QUEUE_DEPTH));
			end
			S_FETCH: begin
				mem_ra = k_q;
			end
			S_SHIFT: begin
				mem_we = pend_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= drs_pkg::POL_FIFO;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			heading_q   <= 1'b0;
			active_q    <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						head_q       <= s_tdata[47:32];
						res_id_q     <= 16'd0;
						res_track_q  <= 16'd0;
						ptr_q        <= '0;
						pend_q       <= 1'b0;
						hit_q        <= 1'b0;
						up_ok_q      <= 1'b0;
						dn_ok_q      <= 1'b0;
						any_q        <= 1'b0;
						k_q          <= '0;
						if (s_tuser[0] == drs_pkg::OP_ADD) begin
							if (count_q < CW'(drs_pkg::QUEUE_DEPTH)) begin
								count_q      <= count_q + CW'(1);
								res_status_q <= drs_pkg::ST_ADDED;
							end else begin
								res_status_q <= drs_pkg::ST_FULL;
							end
							state_q <= S_FINISH;
						end else if (count_q == '0) begin
							res_status_q <= drs_pkg::ST_EMPTY;
							state_q      <= S_FINISH;
						end else if (policy_q == drs_pkg::POL_FLOOK) begin
							state_q <= S_CHECK;
						end else if (is_sstf || is_look || is_clook) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_CHECK, S_SCAN: begin
					if (ptr_more) begin
						pend_q <= 1'b1;
						idx_q  <= ptr_q[IW-1:0];
						ptr_q  <= ptr_q + CW'(1);
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q) begin
						if (state_q == S_CHECK) begin
							if (rdata_q.batch == active_q) begin
								any_q <= 1'b1;
							end
						end else if (elig && !hit_q) begin
							if (t_eq) begin
								hit_q   <= 1'b1;
								hit_i_q <= idx_q;
							end else if (t_gt) begin
								if (!up_ok_q || d_less) begin
									up_ok_q <= 1'b1;
									up_d_q  <= gap;
									up_i_q  <= idx_q;
								end
							end else if (!dn_ok_q || (is_clook ? d_greater : d_less)) begin
								dn_ok_q <= 1'b1;
								dn_d_q  <= gap;
								dn_i_q  <= idx_q;
							end
						end
					end
					if (!pend_q && !ptr_more) begin
						ptr_q <= '0;
						if (state_q == S_CHECK) begin
							if (!any_q) begin
								active_q  <= ~active_q;
								heading_q <= 1'b1;
							end
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					k_q       <= dec_k;
					heading_q <= dec_heading;
					state_q   <= S_FETCH;
				end
				S_FETCH: begin
					state_q <= S_GRANT;
				end
				S_GRANT: begin
					res_id_q     <= rdata_q.ident;
					res_track_q  <= rdata_q.track;
					res_status_q <= drs_pkg::ST_GRANTED;
					ptr_q        <= CW'(k_q) + CW'(1);
					wa_q         <= k_q;
					pend_q       <= 1'b0;
					state_q      <= S_SHIFT;
				end
				S_SHIFT: begin
					if (ptr_more) begin
						pend_q <= 1'b1;
						ptr_q  <= ptr_q + CW'(1);
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q) begin
						wa_q <= wa_q + IW'(1);
					end
					if (!pend_q && !ptr_more) begin
						count_q <= count_q - CW'(1);
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= res_status_q;
						out_id_q      <= res_id_q;
						out_track_q   <= res_track_q;
						out_heading_q <= heading_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
